/* rtl/sled_pkg.sv */
// Shared types, constants and helpers of the smoothed LED meter with gain control.
package sled_pkg;

    localparam int LEVEL_W = 16;
    localparam int DIR_W   = 6;
    localparam int ROWS_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int INERTIA_W = 8;

    // Levels in signed Q8.8 dB
    localparam int Q_STEP_DB = 768;
    localparam int Q_HALF_DB = 128;
    localparam int Q_LOW_DB  = -4608;
    localparam int Q_HIGH_DB = -768;
    localparam int Q_MID_DB  = -2304;

    localparam logic signed [LEVEL_W-1:0] SMOOTH_INIT = -16'sd7680;
    localparam logic signed [LEVEL_W-1:0] LEVEL_MIN   = -16'sd32768;

    localparam logic [INERTIA_W-1:0]      INERTIA_INIT   = 8'd230;
    localparam logic signed [LEVEL_W-1:0] MIN_GAIN_INIT  = -16'sd7680;
    localparam logic signed [LEVEL_W-1:0] MAX_GAIN_INIT  = 16'sd7680;
    localparam logic signed [LEVEL_W-1:0] RED_INIT       = 16'sd0;

    localparam logic [CFG_IDX_W-1:0] CFG_INERTIA  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RED      = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_GAIN,
        ST_EM_RD,
        ST_EM_LD
    } state_t;

    // Threshold of rows below the red one: -3 dB per row
    function automatic logic signed [LEVEL_W-1:0] row_threshold(input int row);
        return LEVEL_W'(-Q_STEP_DB * row);
    endfunction

endpackage

/* rtl/smoothed_led_meter_agc.sv */
// Top level of the smoothed multi-direction LED meter with automatic gain.
//
//  channel  | dir | handshake                      | payload
//  ---------+-----+--------------------------------+---------------------------------------
//  s_axis   | in  | s_axis_tvalid / s_axis_tready  | tdata: energy_db[15:0]; tlast: last_direction
//  m_axis   | out | m_axis_tvalid / m_axis_tready  | tdata: direction, lit_rows, applied_gain;
//           |     |                                |        tlast: last_bar
//  cfg      | in  | cfg_wr_en (no wait)            | cfg_index, cfg_data[15:0]
//
// Each input item goes through memory read, multiply, then accumulate and
// write back to the smoothed-level RAM; the registered read and product split these steps.
// A last item adds a gain update and then a RAM read and a bar load for each of
// the NUM_DIRS bars; each load waits while the output is stalled.
// After reset every direction reads as -30 dB through a valid bit per entry;
// the gain is 0 dB and no clearing pass is needed.
// The finished bar waits in the output register, so a stalled output holds
// only the bar walk; new items are taken again once the last bar is loaded.
module smoothed_led_meter_agc
    import sled_pkg::*;
#(
    parameter int NUM_DIRS = 16,
    parameter int NUM_ROWS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // slave side
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [15:0]          s_axis_tdata,   // [15:0] energy_db
    input  logic                 s_axis_tlast,   // last_direction
    // master side
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [39:0]          m_axis_tdata,   // [5:0] direction, [21:6] lit_rows,
                                                 // [37:22] applied_gain, [39:38] zero
    output logic                 m_axis_tlast,   // last_bar
    // configuration
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    localparam int AW = (NUM_DIRS > 1) ? $clog2(NUM_DIRS) : 1;
    localparam logic [AW-1:0] DIR_LAST = AW'(NUM_DIRS - 1);
    localparam int PW = LEVEL_W + 9;   // inertia times level difference
    localparam int TW = PW + 1;        // blended sum before the shift

    // configuration registers
    logic [INERTIA_W-1:0]      inertia_reg;
    logic signed [LEVEL_W-1:0] min_gain_reg;
    logic signed [LEVEL_W-1:0] max_gain_reg;
    logic signed [LEVEL_W-1:0] red_reg;

    // control and datapath registers
    state_t                    state_reg, state_next;
    logic [AW-1:0]             dir_reg, dir_next;
    logic [AW-1:0]             emit_reg, emit_next;
    logic [NUM_DIRS-1:0]       valid_reg, valid_next;
    logic signed [LEVEL_W-1:0] fresh_reg, fresh_next;
    logic                      last_reg, last_next;
    logic signed [PW-1:0]      prod_reg, prod_next;
    logic signed [LEVEL_W-1:0] peak_reg, peak_next;
    logic                      out_valid_reg, out_valid_next;
    logic [39:0]               out_data_reg, out_data_next;
    logic                      out_last_reg, out_last_next;

    // FSM outputs
    logic                      in_ready;
    logic                      ram_re;
    logic                      ram_we;
    logic [AW-1:0]             ram_raddr;
    logic                      gain_update;
    logic                      bar_load;

    logic [LEVEL_W-1:0]        ram_rdata;
    logic [AW-1:0]             rd_dir;
    logic signed [LEVEL_W-1:0] stored;
    logic signed [LEVEL_W:0]   diff;
    logic signed [TW-1:0]      blend_sum;
    logic signed [LEVEL_W-1:0] smoothed;
    logic signed [LEVEL_W-1:0] gain;
    logic [ROWS_W-1:0]         lit_rows;
    logic                      slot_free;
    logic                      in_accept;

    assign in_accept = s_axis_tvalid && in_ready;
    assign slot_free = !out_valid_reg || m_axis_tready;

    // ---------------------------------------------------------------
    // Configuration writes
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inertia_reg  <= INERTIA_INIT;
            min_gain_reg <= MIN_GAIN_INIT;
            max_gain_reg <= MAX_GAIN_INIT;
            red_reg      <= RED_INIT;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_INERTIA:  inertia_reg  <= cfg_data[INERTIA_W-1:0];
                CFG_MIN_GAIN: min_gain_reg <= cfg_data;
                CFG_MAX_GAIN: max_gain_reg <= cfg_data;
                CFG_RED:      red_reg      <= cfg_data;
                default:      ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:   state_next = ST_ACC;
            ST_ACC:   state_next = last_reg ? ST_GAIN : ST_IDLE;
            ST_GAIN:  state_next = ST_EM_RD;
            ST_EM_RD: state_next = ST_EM_LD;
            ST_EM_LD:
            begin
                if (slot_free)
                begin
                    state_next = (emit_reg == DIR_LAST) ? ST_IDLE : ST_EM_RD;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: outputs
    // ---------------------------------------------------------------
    always_comb
    begin
        in_ready    = 1'b0;
        ram_re      = 1'b0;
        ram_we      = 1'b0;
        ram_raddr   = dir_reg;
        gain_update = 1'b0;
        bar_load    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                ram_re   = 1'b1;
            end
            ST_MUL:   ;
            ST_ACC:   ram_we = 1'b1;
            ST_GAIN:  gain_update = 1'b1;
            ST_EM_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = emit_reg;
            end
            ST_EM_LD: bar_load = slot_free;
            default:  ;
        endcase
    end

    assign s_axis_tready = in_ready;

    // ---------------------------------------------------------------
    // Datapath
    // ---------------------------------------------------------------
    // Entries never written since reset read as -30 dB
    assign rd_dir = (state_reg == ST_EM_LD) ? emit_reg : dir_reg;
    assign stored = valid_reg[rd_dir] ? $signed(ram_rdata) : SMOOTH_INIT;

    // s = (fresh*256 + inertia*(old - fresh) + 128) >>> 8
    assign diff      = {stored[LEVEL_W-1], stored} - {fresh_reg[LEVEL_W-1], fresh_reg};
    assign blend_sum = TW'({fresh_reg, 8'd0}) + TW'(prod_reg) + TW'(128);
    assign smoothed  = blend_sum[LEVEL_W+7:8];

    always_comb
    begin
        fresh_next     = fresh_reg;
        last_next      = last_reg;
        prod_next      = prod_reg;
        dir_next       = dir_reg;
        emit_next      = emit_reg;
        valid_next     = valid_reg;
        peak_next      = peak_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        if (in_accept)
        begin
            fresh_next = s_axis_tdata;
            last_next  = s_axis_tlast;
        end

        if (state_reg == ST_MUL)
        begin
            prod_next = $signed({1'b0, inertia_reg}) * diff;
        end

        if (ram_we)
        begin
            valid_next[dir_reg] = 1'b1;
            if (smoothed > peak_reg)
            begin
                peak_next = smoothed;
            end
            if (last_reg || dir_reg == DIR_LAST)
            begin
                dir_next = '0;
            end
            else
            begin
                dir_next = dir_reg + 1'b1;
            end
        end

        if (gain_update)
        begin
            peak_next = LEVEL_MIN;
            emit_next = '0;
        end

        // drop the bar once taken, then reload from the walk
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (bar_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {2'b00, gain, lit_rows, DIR_W'(emit_reg)};
            out_last_next  = (emit_reg == DIR_LAST);
            emit_next      = emit_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dir_reg       <= '0;
            emit_reg      <= '0;
            valid_reg     <= '0;
            peak_reg      <= LEVEL_MIN;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dir_reg       <= dir_next;
            emit_reg      <= emit_next;
            valid_reg     <= valid_next;
            peak_reg      <= peak_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fresh_reg    <= fresh_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    // ---------------------------------------------------------------
    // Units
    // ---------------------------------------------------------------
    sled_ram #(
        .WIDTH (LEVEL_W),
        .DEPTH (NUM_DIRS)
    ) u_smooth_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (dir_reg),
        .wdata (smoothed),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sled_gain u_gain (
        .clk      (clk),
        .rst_n    (rst_n),
        .update   (gain_update),
        .peak     (peak_reg),
        .min_gain (min_gain_reg),
        .max_gain (max_gain_reg),
        .gain     (gain)
    );

    sled_bar #(
        .NUM_ROWS (NUM_ROWS)
    ) u_bar (
        .smoothed      (stored),
        .gain          (gain),
        .red_threshold (red_reg),
        .lit_rows      (lit_rows)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // one item at a time: no second item while the first is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("item accepted while previous item in flight");

    // the frame's final bar belongs to the highest direction
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[5:0] == DIR_W'(NUM_DIRS - 1)))
        else $error("last bar carries wrong direction");

    // the bar walk starts only straight after a gain update
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EM_RD && emit_reg == '0) |-> $past(gain_update))
        else $error("bar walk started without gain update");

    // a bar is loaded only into a free output slot
    assert property (@(posedge clk) disable iff (!rst_n)
        bar_load |-> (!out_valid_reg || m_axis_tready))
        else $error("bar overwrote a pending output item");

endmodule

/* rtl/sled_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module sled_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/sled_gain.sv */
// Gain register and its once-per-frame update from the frame's peak level.
module sled_gain
    import sled_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      update,
    input  logic signed [LEVEL_W-1:0] peak,
    input  logic signed [LEVEL_W-1:0] min_gain,
    input  logic signed [LEVEL_W-1:0] max_gain,
    output logic signed [LEVEL_W-1:0] gain
);

    localparam int GW = LEVEL_W + 3;

    logic signed [LEVEL_W-1:0] gain_reg;
    logic signed [LEVEL_W-1:0] gain_next;
    logic signed [LEVEL_W:0]   level;
    logic signed [GW-1:0]      lvl_w;
    logic signed [GW-1:0]      g_w;
    logic signed [GW-1:0]      lo_w;
    logic signed [GW-1:0]      hi_w;
    logic signed [GW-1:0]      cand;

    always_comb
    begin
        level = {peak[LEVEL_W-1], peak} + {gain_reg[LEVEL_W-1], gain_reg};
        lvl_w = GW'(level);
        g_w   = GW'(gain_reg);
        lo_w  = GW'(min_gain);
        hi_w  = GW'(max_gain);
        cand  = g_w;
        if (lvl_w > GW'(0))
        begin
            cand = g_w - lvl_w - GW'(Q_STEP_DB);
            if (cand < lo_w)
            begin
                cand = lo_w;
            end
        end
        else if (lvl_w < GW'(Q_LOW_DB))
        begin
            cand = g_w - lvl_w;
            if (cand > hi_w)
            begin
                cand = hi_w;
            end
        end
        else if (lvl_w > GW'(Q_HIGH_DB))
        begin
            cand = g_w - GW'(Q_HALF_DB);
            if (cand < lo_w)
            begin
                cand = lo_w;
            end
        end
        else if (lvl_w < GW'(Q_MID_DB))
        begin
            cand = g_w + GW'(Q_HALF_DB);
            if (cand > hi_w)
            begin
                cand = hi_w;
            end
        end

        gain_next = gain_reg;
        if (update)
        begin
            if (cand > GW'(32767))
            begin
                gain_next = 16'sd32767;
            end
            else if (cand < GW'(-32768))
            begin
                gain_next = -16'sd32768;
            end
            else
            begin
                gain_next = cand[LEVEL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= '0;
        end
        else
        begin
            gain_reg <= gain_next;
        end
    end

    assign gain = gain_reg;

endmodule

/* rtl/sled_bar.sv */
// Bar encoder: gained level against the row thresholds, one bit per row.
module sled_bar
    import sled_pkg::*;
#(
    parameter int NUM_ROWS = 16
) (
    input  logic signed [LEVEL_W-1:0] smoothed,
    input  logic signed [LEVEL_W-1:0] gain,
    input  logic signed [LEVEL_W-1:0] red_threshold,
    output logic [ROWS_W-1:0]         lit_rows
);

    logic signed [LEVEL_W:0]   sum;
    logic signed [LEVEL_W-1:0] gained;

    always_comb
    begin
        sum = {smoothed[LEVEL_W-1], smoothed} + {gain[LEVEL_W-1], gain};
        if (sum > 17'sd32767)
        begin
            gained = 16'sd32767;
        end
        else if (sum < -17'sd32768)
        begin
            gained = -16'sd32768;
        end
        else
        begin
            gained = sum[LEVEL_W-1:0];
        end

        for (int i = 0; i < ROWS_W; i++)
        begin
            if (i >= NUM_ROWS)
            begin
                lit_rows[i] = 1'b0;
            end
            else if (i == 0)
            begin
                lit_rows[i] = gained > red_threshold;
            end
            else
            begin
                lit_rows[i] = gained > row_threshold(i);
            end
        end
    end

endmodule

/* test/bar_checker.sv */
// Checker of the LED meter: predicts each bar from the observed items and registers, and compares.
module bar_checker
    import sled_pkg::*;
#(
    parameter int NUM_DIRS = 16,
    parameter int NUM_ROWS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [15:0]          s_axis_tdata,   // [15:0] energy_db
    input  logic                 s_axis_tlast,   // last_direction
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [39:0]          m_axis_tdata,   // [5:0] direction, [21:6] lit_rows,
                                                 // [37:22] applied_gain, [39:38] zero
    input  logic                 m_axis_tlast,   // last_bar
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    output int                   mismatches,
    output int                   pending
);

    typedef struct packed {
        logic [DIR_W-1:0]          direction;
        logic [ROWS_W-1:0]         lit_rows;
        logic signed [LEVEL_W-1:0] gain;
        logic                      last_bar;
    } bar_t;

    localparam int PRINT_CAP = 40;

    // Register copies
    logic [INERTIA_W-1:0]      weight;
    logic signed [LEVEL_W-1:0] gain_floor;
    logic signed [LEVEL_W-1:0] gain_ceil;
    logic signed [LEVEL_W-1:0] red_level;

    // Meter state
    logic signed [LEVEL_W-1:0] level_mem [NUM_DIRS];
    logic signed [LEVEL_W-1:0] gain_now;
    logic signed [LEVEL_W-1:0] peak;
    int                        slot;

    bar_t bars_due [$];

    initial mismatches = 0;

    function automatic logic signed [LEVEL_W-1:0] clip16(input int v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[LEVEL_W-1:0];
    endfunction

    task automatic report_fault(input string msg);
        if (mismatches < PRINT_CAP)
            $display("[%0t] bar fault: %s", $realtime, msg);
        mismatches++;
    endtask

    // Blend one energy into its direction; on a closing item update the gain
    // and queue one bar per direction.
    task automatic absorb_energy(input logic signed [LEVEL_W-1:0] fresh, input logic closes);
        int               blended;
        int               lvl;
        int               g;
        int               e;
        int               th;
        logic [ROWS_W-1:0] mask;
        bar_t             bar;
        blended = ((256 - int'(weight)) * int'(fresh) + int'(weight) * int'(level_mem[slot])
                   + 128) >>> 8;
        level_mem[slot] = blended[LEVEL_W-1:0];
        if (blended > int'(peak))
            peak = blended[LEVEL_W-1:0];
        slot = (slot + 1 >= NUM_DIRS) ? 0 : slot + 1;
        if (!closes)
            return;

        lvl = int'(peak) + int'(gain_now);
        g   = int'(gain_now);
        if (lvl > 0) begin
            g = g - lvl - Q_STEP_DB;
            if (g < int'(gain_floor))
                g = int'(gain_floor);
        end else if (lvl < Q_LOW_DB) begin
            g = g - lvl;
            if (g > int'(gain_ceil))
                g = int'(gain_ceil);
        end else if (lvl > Q_HIGH_DB) begin
            g = g - Q_HALF_DB;
            if (g < int'(gain_floor))
                g = int'(gain_floor);
        end else if (lvl < Q_MID_DB) begin
            g = g + Q_HALF_DB;
            if (g > int'(gain_ceil))
                g = int'(gain_ceil);
        end
        gain_now = clip16(g);

        for (int j = 0; j < NUM_DIRS; j++) begin
            e    = int'(clip16(int'(level_mem[j]) + int'(gain_now)));
            mask = '0;
            for (int i = 0; i < NUM_ROWS && i < ROWS_W; i++) begin
                th = (i == 0) ? int'(red_level) : -Q_STEP_DB * i;
                if (e > th)
                    mask[i] = 1'b1;
            end
            bar.direction = DIR_W'(j);
            bar.lit_rows  = mask;
            bar.gain      = gain_now;
            bar.last_bar  = (j == NUM_DIRS - 1);
            bars_due = {bars_due, bar};
        end
        peak = LEVEL_MIN;
        slot = 0;
    endtask

    task automatic check_bar();
        bar_t want;
        if (bars_due.size() == 0) begin
            report_fault($sformatf("bar for direction %0d with nothing expected",
                                   m_axis_tdata[5:0]));
            return;
        end
        want = bars_due.pop_front();
        if (m_axis_tdata[5:0] !== want.direction)
            report_fault($sformatf("direction %0d, expected %0d",
                                   m_axis_tdata[5:0], want.direction));
        if (m_axis_tdata[21:6] !== want.lit_rows)
            report_fault($sformatf("direction %0d lit_rows %h, expected %h",
                                   want.direction, m_axis_tdata[21:6], want.lit_rows));
        if (m_axis_tdata[37:22] !== want.gain)
            report_fault($sformatf("direction %0d applied_gain %0d, expected %0d", want.direction,
                                   $signed(m_axis_tdata[37:22]), want.gain));
        if (m_axis_tlast !== want.last_bar)
            report_fault($sformatf("direction %0d last_bar %b, expected %b",
                                   want.direction, m_axis_tlast, want.last_bar));
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            weight     = INERTIA_INIT;
            gain_floor = MIN_GAIN_INIT;
            gain_ceil  = MAX_GAIN_INIT;
            red_level  = RED_INIT;
            for (int j = 0; j < NUM_DIRS; j++)
                level_mem[j] = SMOOTH_INIT;
            gain_now = '0;
            peak     = LEVEL_MIN;
            slot     = 0;
            bars_due.delete();
            pending <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                check_bar();
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_INERTIA:  weight     = cfg_data[INERTIA_W-1:0];
                    CFG_MIN_GAIN: gain_floor = cfg_data;
                    CFG_MAX_GAIN: gain_ceil  = cfg_data;
                    CFG_RED:      red_level  = cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                absorb_energy(s_axis_tdata, s_axis_tlast);
            pending <= bars_due.size();
        end
    end

endmodule

/* test/tb_top.sv */
// Top of the LED meter testbench: clock, reset, stimulus, output pacing and the verdict.
module tb_top;
    import sled_pkg::*;

    localparam int NUM_DIRS     = 16;
    localparam int NUM_ROWS     = 16;
    localparam int PHASE_ITEMS  = 66;   // items per random phase, six phases
    localparam int SETTLE       = 12;   // item pipeline plus gain update, with margin
    localparam int HOLD_CYCLES  = 400;  // long output stall, longer than any frame takes

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Slave side, driven here
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        s_tready;

    // Master side
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;

    // Configuration port
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_INERTIA;
    logic [15:0]          cfg_data  = '0;

    // Pacing: percent of cycles in which each side idles
    int   send_idle  = 18;
    int   recv_idle  = 49;
    logic start_hold = 1'b0;
    logic hold_off   = 1'b0;

    int mismatches;
    int pending;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    smoothed_led_meter_agc #(
        .NUM_DIRS (NUM_DIRS),
        .NUM_ROWS (NUM_ROWS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tlast  (s_tlast),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tlast  (m_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    bar_checker #(
        .NUM_DIRS (NUM_DIRS),
        .NUM_ROWS (NUM_ROWS)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tlast  (s_tlast),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tlast  (m_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    // Receiver: drop tready at random, and hold it low throughout a hold-off.
    always @(posedge clk)
    begin
        m_tready <= !hold_off && ($urandom_range(0, 99) >= recv_idle);
    end

    // Long output stall: once asked, keep the receiver off for a fixed count of
    // cycles while the sender keeps offering, so the bar walk backs up into the input.
    initial
    begin : hold_process
        int count;
        while (!start_hold)
            @(posedge clk);
        hold_off <= 1'b1;
        for (count = 0; count < HOLD_CYCLES; count++)
            @(posedge clk);
        hold_off <= 1'b0;
    end

    // Watchdog: end the run as failed once its time limit is reached, as when the handshakes stop moving.
    initial
    begin
        #1000000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic set_pace(input int sender_pct, input int receiver_pct);
        send_idle <= sender_pct;
        recv_idle <= receiver_pct;
    endtask

    // Drive one register and let the clock edge take it; the caller lowers the enable.
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic write_regs(input logic [7:0] inertia, input logic [15:0] lo_gain,
                              input logic [15:0] hi_gain, input logic [15:0] red);
        put_reg(CFG_INERTIA, {8'd0, inertia});
        put_reg(CFG_MIN_GAIN, lo_gain);
        put_reg(CFG_MAX_GAIN, hi_gain);
        put_reg(CFG_RED, red);
        cfg_wr_en <= 1'b0;
    endtask

    // Offer one item after a random idle stretch, and hold it until taken.
    task automatic send_item(input logic [15:0] energy, input logic last);
        while ($urandom_range(0, 99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= energy;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Mostly levels a room would give, some full-range noise and some extremes.
    function automatic logic [15:0] pick_energy();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 16'($urandom_range(0, 65535));
        if (r < 14)
        begin
            case ($urandom_range(0, 3))
                0:       return 16'h7fff;
                1:       return 16'h8000;
                2:       return 16'h0000;
                default: return 16'hffff;
            endcase
        end
        return 16'($urandom_range(0, 12800) - 10240);
    endfunction

    // Mostly whole frames; some short ones and some that wrap past the last direction.
    function automatic int pick_frame_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return NUM_DIRS;
        if (r < 85)
            return $urandom_range(1, NUM_DIRS - 1);
        return $urandom_range(NUM_DIRS + 1, 40);
    endfunction

    task automatic send_frames(input int quota);
        int sent;
        int len;
        sent = 0;
        while (sent < quota)
        begin
            len = pick_frame_len();
            for (int k = 0; k < len; k++)
                send_item(pick_energy(), k == len - 1);
            sent += len;
        end
    endtask

    // Stop offering, wait for every expected bar, then let the pipeline settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, on the reset register values.
        // A frame of one item: the other directions keep their reset level.
        send_item(16'h7fff, 1'b1);
        // A short frame through the most negative, minus one LSB and zero.
        send_item(16'h8000, 1'b0);
        send_item(16'hffff, 1'b0);
        send_item(16'h0000, 1'b1);
        // A long frame: the direction index wraps and the first directions are blended twice.
        for (int k = 0; k < NUM_DIRS + 2; k++)
            send_item(k[0] ? 16'h8000 : 16'h7fff, k == NUM_DIRS + 1);
        drain();

        // Random phases: sender idles lightly first, then the receiver, then neither.
        for (int phase = 1; phase <= 6; phase++)
        begin
            case (phase)
                1, 2:    set_pace(18, 49);
                3, 4:    set_pace(49, 18);
                default: set_pace(0, 0);
            endcase
            case (phase)
                // No smoothing, widest gain range
                1: write_regs(8'd0, 16'h8000, 16'h7fff, 16'($urandom_range(0, 65535)));
                // Heaviest smoothing, crossed bounds, lowest red threshold
                2: write_regs(8'd255, 16'sd2000, -16'sd2000, 16'h8000);
                // Moderate bounds, red row never lit
                3: write_regs(8'($urandom_range(0, 255)), 16'($urandom_range(0, 11000) - 12000),
                              16'($urandom_range(1000, 12000)), 16'h7fff);
                // Crossed at the extremes: the gain jumps between the rails
                4: write_regs(8'd128, 16'h7fff, 16'h8000, 16'($urandom_range(0, 65535)));
                // Reset bounds again, with a long output stall early on
                5: write_regs(8'($urandom_range(0, 255)), MIN_GAIN_INIT, MAX_GAIN_INIT,
                              RED_INIT);
                default: write_regs(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                                    16'($urandom_range(0, 65535)),
                                    16'($urandom_range(0, 65535)));
            endcase
            if (phase == 5)
                start_hold <= 1'b1;
            send_frames(PHASE_ITEMS);
            drain();
        end

        if (mismatches == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/sled_pkg.sv
rtl/sled_ram.sv
rtl/sled_gain.sv
rtl/sled_bar.sv
rtl/smoothed_led_meter_agc.sv
test/bar_checker.sv
test/tb_top.sv
